// ===== rtl/pulse_rate_speed_estimator_macros.svh =====
// ---------------------------------------------------------------------------
// Pulse rate speed estimator assertion macros
// Concurrent assertion helpers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PULSE_RATE_SPEED_ESTIMATOR_MACROS_SVH
`define PULSE_RATE_SPEED_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PRSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define PRSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define PRSE_ASSERT(lbl, prop)
`define PRSE_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== rtl/prse_pkg.sv =====
// ---------------------------------------------------------------------------
// Pulse rate speed estimator package
// Shared constants, register indexes and sequencer state codes.
// ---------------------------------------------------------------------------
package prse_pkg;

    localparam int MAX_BINS_DEF = 512;
    localparam int TICK_MS_DEF  = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_MODE = 3'd0,
        CFG_SENSOR_CENTER = 3'd1,
        CFG_TRIGGER_THRESHOLD = 3'd2,
        CFG_WINDOW1_MS = 3'd3,
        CFG_WINDOW2_MS = 3'd4,
        CFG_MAX_SPEED = 3'd5
    } cfg_idx_t;

    localparam logic        CMD_SAMPLE = 1'b0;
    localparam logic        CMD_TICK   = 1'b1;

    localparam logic        MODE_ANALOG = 1'b0;

    localparam logic [9:0]  CENTER_RST    = 10'd512;
    localparam logic [9:0]  THRESHOLD_RST = 10'd100;
    localparam logic [11:0] WINDOW1_RST   = 12'd1000;
    localparam logic [11:0] WINDOW2_RST   = 12'd500;
    localparam logic [6:0]  MAX_SPEED_RST = 7'd10;

    localparam logic [9:0]  RELEASE_GAP = 10'd10;
    localparam logic [9:0]  RELEASE_MIN = 10'd2;
    localparam logic [15:0] SAT16       = 16'hFFFF;
    localparam logic [16:0] SPEED_ONE   = 17'h10000;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_WIN1    = 10'b00_0000_0010,
        S_WIN2    = 10'b00_0000_0100,
        S_BIN_WR  = 10'b00_0000_1000,
        S_BIN_RD  = 10'b00_0001_0000,
        S_HIST_WR = 10'b00_0010_0000,
        S_HIST_RD = 10'b00_0100_0000,
        S_MEAN    = 10'b00_1000_0000,
        S_SPEED   = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

// ===== rtl/prse_div.sv =====
// ---------------------------------------------------------------------------
// Pulse rate speed estimator divider
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ---------------------------------------------------------------------------
module prse_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                    cnt_reg  <= cnt_reg - 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract when it fits
            rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/pulse_rate_speed_estimator.sv =====
// Sample transaction: accepted back to back while no tick is in progress, no result.
// Tick transaction: input stalled throughout; one history write (up to n2 on refill), window sums
//   read one entry a cycle, then two divides, NUM_W = 16+clog2(MAX_BINS+1)+16 bits wide, on the
//   shared bit-serial divider.
// Result register decouples the output; a finished tick holds only while that register is full and stalled.
// Reset clears control state; the bin ring reads as zero through a fill count, no clear pass.
// ---------------------------------------------------------------------------
// Pulse rate speed estimator
// Hysteresis pulse detector (summed sample values in pulse mode) with windowed counts, moving average and speed.
// ---------------------------------------------------------------------------
`include "pulse_rate_speed_estimator_macros.svh"

module pulse_rate_speed_estimator #(
    parameter int MAX_BINS = prse_pkg::MAX_BINS_DEF,
    parameter int TICK_MS  = prse_pkg::TICK_MS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            cmd,
    input  logic [9:0]                      sample_value,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [15:0]                     raw_count,
    output logic [23:0]                     smoothed_q8,
    output logic [16:0]                     speed_q16,
    output logic                            near_flag
);
    import prse_pkg::*;

    localparam int PTR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int DEN_W = CNT_W + 7;
    localparam int NUM_W = SUM_W + 16;
    localparam int RECIP_SH = 24;
    localparam logic [RECIP_SH:0] TICK_RECIP =
        (RECIP_SH + 1)'(((1 << RECIP_SH) + TICK_MS - 1) / TICK_MS);

    // configuration
    logic        mode_reg;
    logic [9:0]  center_reg;
    logic [9:0]  thresh_reg;
    logic [11:0] win1_reg;
    logic [11:0] win2_reg;
    logic [6:0]  mspeed_reg;

    state_t state_reg, state_next;

    logic             near_reg;
    logic [15:0]      cur_bin_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] hp_reg;
    logic [CNT_W-1:0] bins_wr_reg;
    logic [CNT_W-1:0] filled_reg;
    logic [CNT_W-1:0] n1_reg;
    logic [CNT_W-1:0] n2_reg;
    logic [CNT_W-1:0] k_reg;
    logic             pend_reg;
    logic             ok_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [15:0]      raw_reg;
    logic [23:0]      q8_reg;
    logic [16:0]      sp_reg;

    logic             result_valid_reg;
    logic [15:0]      raw_count_reg;
    logic [23:0]      smoothed_q8_reg;
    logic [16:0]      speed_q16_reg;
    logic             near_flag_reg;

    // memories
    logic [15:0]      bin_mem [MAX_BINS];
    logic [15:0]      hist_mem [MAX_BINS];
    logic [15:0]      bin_rdata;
    logic [15:0]      hist_rdata;
    logic             bin_we;
    logic             hist_we;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W-1:0] hp_inc;
    logic [PTR_W-1:0] rd_addr;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [CNT_W-1:0] win_len;

    // window length
    logic [11:0]          win_ms;
    logic [RECIP_SH+12:0] win_prod;
    logic [12:0]          win_q;

    logic             item_acc;
    logic             res_free;
    logic [9:0]       diff;
    logic [9:0]       release_lvl;
    logic [16:0]      bin_add;
    logic [CNT_W-1:0] loop_n;
    logic             loop_busy;
    logic             loop_end;
    logic [CNT_W:0]   back_idx;
    logic [CNT_W-1:0] fill_inc;
    logic [6:0]       mspeed_eff;
    logic [DEN_W-1:0] prod;

    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign res_free   = !result_valid_reg || !result_stall;

    assign rp_inc = (rp_reg == PTR_W'(MAX_BINS - 1)) ? '0 : PTR_W'(rp_reg + 1'b1);
    assign hp_inc = (hp_reg == PTR_W'(MAX_BINS - 1)) ? '0 : PTR_W'(hp_reg + 1'b1);

    // sample path
    always_comb
    begin
        diff = (sample_value > center_reg) ? 10'(sample_value - center_reg)
                                           : 10'(center_reg - sample_value);
        release_lvl = (thresh_reg >= RELEASE_GAP + RELEASE_MIN) ? 10'(thresh_reg - RELEASE_GAP)
                                                                  : RELEASE_MIN;
        if (mode_reg == MODE_ANALOG)
            bin_add = {1'b0, cur_bin_reg} + 17'd1;
        else
            bin_add = {1'b0, cur_bin_reg} + 17'(sample_value);
    end

    // window length: ms / TICK_MS by reciprocal multiplication, exact for 12-bit ms
    always_comb
    begin
        win_ms   = (state_reg == S_WIN1) ? win1_reg : win2_reg;
        win_prod = (RECIP_SH + 13)'(win_ms) * (RECIP_SH + 13)'(TICK_RECIP);
        win_q    = win_prod[RECIP_SH+12:RECIP_SH];
        if (win_q == '0)
            win_len = CNT_W'(1);
        else if (win_q > 13'(MAX_BINS))
            win_len = CNT_W'(MAX_BINS);
        else
            win_len = win_q[CNT_W-1:0];
    end

    // read loop over the newest loop_n entries
    always_comb
    begin
        loop_n    = (state_reg == S_BIN_RD) ? n1_reg : filled_reg;
        loop_busy = (k_reg < loop_n);
        loop_end  = !loop_busy && !pend_reg;
        if (state_reg == S_BIN_RD)
            back_idx = (CNT_W + 1)'(rp_reg);
        else
            back_idx = (CNT_W + 1)'(hp_reg);
        if ({1'b0, k_reg} > back_idx)
            back_idx = (CNT_W + 1)'(back_idx + (CNT_W + 1)'(MAX_BINS) - {1'b0, k_reg});
        else
            back_idx = (CNT_W + 1)'(back_idx - {1'b0, k_reg});
        rd_addr = back_idx[PTR_W-1:0];
    end

    assign fill_inc   = (filled_reg < CNT_W'(MAX_BINS)) ? CNT_W'(filled_reg + 1'b1) : filled_reg;
    assign mspeed_eff = (mspeed_reg == '0) ? 7'd1 : mspeed_reg;
    assign prod       = DEN_W'(filled_reg * mspeed_eff);
    assign bin_we     = (state_reg == S_BIN_WR);
    assign hist_we    = (state_reg == S_HIST_WR);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && cmd == CMD_TICK)
                    state_next = S_WIN1;
            end
            S_WIN1:    state_next = S_WIN2;
            S_WIN2:    state_next = S_BIN_WR;
            S_BIN_WR:  state_next = S_BIN_RD;
            S_BIN_RD:
            begin
                if (loop_end)
                    state_next = S_HIST_WR;
            end
            S_HIST_WR:
            begin
                if (fill_inc >= n2_reg)
                    state_next = S_HIST_RD;
            end
            S_HIST_RD:
            begin
                if (loop_end)
                begin
                    state_next = S_MEAN;
                    div_start  = 1'b1;
                    div_num    = NUM_W'({acc_reg, 8'd0}) + NUM_W'(filled_reg >> 1);
                    div_den    = DEN_W'(filled_reg);
                end
            end
            S_MEAN:
            begin
                if (div_done)
                begin
                    state_next = S_SPEED;
                    div_start  = 1'b1;
                    div_num    = NUM_W'({acc_reg, 16'd0}) + NUM_W'(prod >> 1);
                    div_den    = prod;
                end
            end
            S_SPEED:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_ANALOG;
            center_reg       <= CENTER_RST;
            thresh_reg       <= THRESHOLD_RST;
            win1_reg         <= WINDOW1_RST;
            win2_reg         <= WINDOW2_RST;
            mspeed_reg       <= MAX_SPEED_RST;
            near_reg         <= 1'b0;
            cur_bin_reg      <= '0;
            rp_reg           <= '0;
            hp_reg           <= '0;
            bins_wr_reg      <= '0;
            filled_reg       <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SENSOR_MODE:       mode_reg   <= cfg_data[0];
                    CFG_SENSOR_CENTER:     center_reg <= cfg_data[9:0];
                    CFG_TRIGGER_THRESHOLD: thresh_reg <= cfg_data[9:0];
                    CFG_WINDOW1_MS:        win1_reg   <= cfg_data;
                    CFG_WINDOW2_MS:        win2_reg   <= cfg_data;
                    CFG_MAX_SPEED:         mspeed_reg <= cfg_data[6:0];
                    default:               ;
                endcase
            end

            if (item_acc && cmd == CMD_SAMPLE)
            begin
                if (mode_reg != MODE_ANALOG)
                begin
                    cur_bin_reg <= (bin_add > 17'(SAT16)) ? SAT16 : bin_add[15:0];
                end
                else if (!near_reg && diff > thresh_reg)
                begin
                    near_reg    <= 1'b1;
                    cur_bin_reg <= (bin_add > 17'(SAT16)) ? SAT16 : bin_add[15:0];
                end
                else if (near_reg && diff < release_lvl)
                begin
                    near_reg <= 1'b0;
                end
            end

            if (state_reg == S_BIN_WR)
            begin
                rp_reg      <= rp_inc;
                cur_bin_reg <= '0;
                if (bins_wr_reg < CNT_W'(MAX_BINS))
                    bins_wr_reg <= CNT_W'(bins_wr_reg + 1'b1);
            end

            if (state_reg == S_HIST_WR)
            begin
                hp_reg     <= hp_inc;
                filled_reg <= (fill_inc >= n2_reg) ? n2_reg : fill_inc;
            end

            if (state_reg == S_BIN_RD || state_reg == S_HIST_RD)
                pend_reg <= loop_busy;
            else
                pend_reg <= 1'b0;

            if (state_reg == S_DONE && res_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIN1)
            n1_reg <= win_len;
        if (state_reg == S_WIN2)
            n2_reg <= win_len;

        if (state_reg == S_BIN_WR || state_reg == S_HIST_WR)
        begin
            k_reg   <= '0;
            acc_reg <= '0;
        end
        else if (state_reg == S_BIN_RD || state_reg == S_HIST_RD)
        begin
            if (loop_busy)
                k_reg <= CNT_W'(k_reg + 1'b1);
            // bins never written read as zero
            ok_reg <= (state_reg == S_HIST_RD) || (k_reg < bins_wr_reg);
            if (pend_reg && ok_reg)
                acc_reg <= SUM_W'(acc_reg + SUM_W'(state_reg == S_BIN_RD ? bin_rdata
                                                                       : hist_rdata));
        end

        if (state_reg == S_BIN_RD && loop_end)
            raw_reg <= (acc_reg > SUM_W'(SAT16)) ? SAT16 : acc_reg[15:0];

        if (state_reg == S_MEAN && div_done)
            q8_reg <= div_quo[23:0];
        if (state_reg == S_SPEED && div_done)
            sp_reg <= (div_quo > NUM_W'(SPEED_ONE)) ? SPEED_ONE : div_quo[16:0];

        if (state_reg == S_DONE && res_free)
        begin
            raw_count_reg   <= raw_reg;
            smoothed_q8_reg <= q8_reg;
            speed_q16_reg   <= sp_reg;
            near_flag_reg   <= near_reg;
        end
    end

    // bin ring memory
    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[rp_inc] <= cur_bin_reg;
        bin_rdata <= bin_mem[rd_addr];
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hp_inc] <= raw_reg;
        hist_rdata <= hist_mem[rd_addr];
    end

    prse_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign result_valid = result_valid_reg;
    assign raw_count    = raw_count_reg;
    assign smoothed_q8  = smoothed_q8_reg;
    assign speed_q16    = speed_q16_reg;
    assign near_flag    = near_flag_reg;

    `PRSE_ASSERT_IMPL(a_result_from_done, $rose(result_valid_reg), $past(state_reg == S_DONE))
    `PRSE_ASSERT(a_filled_bound, filled_reg <= CNT_W'(MAX_BINS))
    `PRSE_ASSERT_IMPL(a_div_in_div_state, div_done, state_reg == S_MEAN || state_reg == S_SPEED)
    `PRSE_ASSERT(a_bins_bound, bins_wr_reg <= CNT_W'(MAX_BINS))

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// Pulse rate speed estimator testbench
// Drives samples and ticks with random bursts and result stalls, predicts
// each tick's counts, average and speed, and compares them field by field.
// ---------------------------------------------------------------------------
module tb_top;
    import prse_pkg::*;

    localparam int NBINS = MAX_BINS_DEF;
    localparam int TICK_LATENCY = 4 * (16 + 10 + 16 + 1) + 3 * NBINS + 20;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [15:0] raw;
        logic [23:0] smooth;
        logic [16:0] speed;
        logic        near;
    } tick_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic        cmd;
    logic [9:0]  sample_value;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] raw_count;
    logic [23:0] smoothed_q8;
    logic [16:0] speed_q16;
    logic        near_flag;

    pulse_rate_speed_estimator dut (.*);

    // predictor state
    logic        m_mode;
    logic [9:0]  m_center;
    logic [9:0]  m_thresh;
    logic [11:0] m_win1;
    logic [11:0] m_win2;
    logic [6:0]  m_maxspd;
    logic        m_near;
    int unsigned m_bin;
    int unsigned m_bins [NBINS];
    int unsigned m_hist [NBINS];
    int unsigned m_filled;
    int unsigned m_bin_ptr;
    int unsigned m_hist_ptr;

    tick_result_t expected_ticks[$];
    int     errors;
    longint cycles;
    int     hold_cycles;
    int     burst_left;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned win_bins(logic [11:0] ms);
        int unsigned n;
        n = ms / TICK_MS_DEF;
        if (n < 1) n = 1;
        if (n > NBINS) n = NBINS;
        return n;
    endfunction

    function automatic int unsigned sat16(int unsigned a, int unsigned b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    task automatic predict_reset();
        m_mode = MODE_ANALOG;
        m_center = CENTER_RST;
        m_thresh = THRESHOLD_RST;
        m_win1 = WINDOW1_RST;
        m_win2 = WINDOW2_RST;
        m_maxspd = MAX_SPEED_RST;
        m_near = 1'b0;
        m_bin = 0;
        m_filled = 0;
        m_bin_ptr = 0;
        m_hist_ptr = 0;
        foreach (m_bins[i]) m_bins[i] = 0;
        foreach (m_hist[i]) m_hist[i] = 0;
    endtask

    task automatic push_history(int unsigned v);
        m_hist_ptr = (m_hist_ptr + 1) % NBINS;
        m_hist[m_hist_ptr] = v;
        if (m_filled < NBINS) m_filled++;
    endtask

    task automatic predict_item(logic c, logic [9:0] v);
        int unsigned n1;
        int unsigned n2;
        int unsigned raw;
        int unsigned diff;
        int unsigned rel;
        int unsigned divisor;
        longint unsigned hsum;
        longint unsigned q8;
        longint unsigned sp;
        tick_result_t r;
        if (c == CMD_TICK)
        begin
            n1 = win_bins(m_win1);
            n2 = win_bins(m_win2);
            m_bin_ptr = (m_bin_ptr + 1) % NBINS;
            m_bins[m_bin_ptr] = m_bin;
            m_bin = 0;
            raw = 0;
            for (int k = 0; k < n1; k++)
                raw = sat16(raw, m_bins[(m_bin_ptr + NBINS - k) % NBINS]);
            push_history(raw);
            if (m_filled > n2) m_filled = n2;
            while (m_filled < n2) push_history(raw);
            hsum = 0;
            for (int k = 0; k < m_filled; k++)
                hsum += m_hist[(m_hist_ptr + NBINS - k) % NBINS];
            q8 = ((hsum << 8) + m_filled / 2) / m_filled;
            divisor = m_filled * ((m_maxspd != 0) ? m_maxspd : 1);
            sp = ((hsum << 16) + divisor / 2) / divisor;
            if (sp > SPEED_ONE) sp = SPEED_ONE;
            r.raw = raw[15:0];
            r.smooth = q8[23:0];
            r.speed = sp[16:0];
            r.near = m_near;
            expected_ticks = {expected_ticks, r};
        end
        else if (m_mode != MODE_ANALOG)
            m_bin = sat16(m_bin, v);
        else
        begin
            diff = (v > m_center) ? v - m_center : m_center - v;
            rel = (m_thresh >= RELEASE_GAP + RELEASE_MIN) ? m_thresh - RELEASE_GAP : RELEASE_MIN;
            if (!m_near && diff > m_thresh)
            begin
                m_near = 1'b1;
                m_bin = sat16(m_bin, 1);
            end
            else if (m_near && diff < rel)
                m_near = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // check each result transaction
    always @(posedge clk)
    begin
        tick_result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_ticks.size() == 0)
                report_mismatch("unexpected result", raw_count, -1);
            else
            begin
                e = expected_ticks.pop_front();
                if (raw_count !== e.raw) report_mismatch("raw_count", raw_count, e.raw);
                if (smoothed_q8 !== e.smooth)
                    report_mismatch("smoothed_q8", smoothed_q8, e.smooth);
                if (speed_q16 !== e.speed) report_mismatch("speed_q16", speed_q16, e.speed);
                if (near_flag !== e.near) report_mismatch("near_flag", near_flag, e.near);
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else if (cycles % 4000 < 1000)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** pulse_rate_speed_estimator: FAILED **");
            $finish;
        end
    end

    // valid stays high inside a burst; drop it only for a gap
    task automatic send_item(logic c, logic [9:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        cmd <= c;
        sample_value <= v;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_item(c, v);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (TICK_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SENSOR_MODE: m_mode = val[0];
            CFG_SENSOR_CENTER: m_center = val[9:0];
            CFG_TRIGGER_THRESHOLD: m_thresh = val[9:0];
            CFG_WINDOW1_MS: m_win1 = val;
            CFG_WINDOW2_MS: m_win2 = val;
            CFG_MAX_SPEED: m_maxspd = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic mode, logic [9:0] ctr, logic [9:0] thr,
                              logic [11:0] w1, logic [11:0] w2, logic [6:0] ms);
        drain();
        write_reg(CFG_SENSOR_MODE, mode);
        write_reg(CFG_SENSOR_CENTER, ctr);
        write_reg(CFG_TRIGGER_THRESHOLD, thr);
        write_reg(CFG_WINDOW1_MS, w1);
        write_reg(CFG_WINDOW2_MS, w2);
        write_reg(CFG_MAX_SPEED, ms);
        cfg_we <= 1'b0;
    endtask

    // analog pulses around the center: swing out then back; then pulse-mode sums and bin saturation
    task automatic test_directed();
        send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 10'd1023);
        send_item(CMD_SAMPLE, 10'd1023);
        send_item(CMD_SAMPLE, 10'd512);
        send_item(CMD_SAMPLE, 10'd0);
        send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 10'd605);
        send_item(CMD_SAMPLE, 10'd520);
        send_item(CMD_TICK, 0);
        set_config(1'b1, 10'd0, 10'd5, 12'd0, 12'd4095, 7'd0);
        send_item(CMD_SAMPLE, 10'd1023);
        send_item(CMD_SAMPLE, 10'h155);
        send_item(CMD_SAMPLE, 10'h2AA);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK, 0);
        // saturate the bin in pulse mode
        repeat (70) send_item(CMD_SAMPLE, 10'd1023);
        send_item(CMD_TICK, 0);
        set_config(1'b0, 10'd1023, 10'd1023, 12'd4095, 12'd9, 7'd127);
        send_item(CMD_SAMPLE, 10'd0);
        send_item(CMD_TICK, 0);
    endtask

    task automatic test_analog_random();
        set_config(1'b0, $urandom_range(300, 700), $urandom_range(5, 300),
                   $urandom_range(10, 300), $urandom_range(10, 300), $urandom_range(1, 5));
        repeat (300)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_TICK, $urandom);
            else
                send_item(CMD_SAMPLE, $urandom);
        end
    endtask

    task automatic test_pulse_random();
        set_config(1'b1, $urandom, $urandom_range(5, 1000),
                   $urandom_range(10, 200), $urandom_range(10, 3000), $urandom_range(1, 100));
        repeat (200)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_TICK, $urandom);
            else
                send_item(CMD_SAMPLE, $urandom_range(0, 8));
        end
    endtask

    // long receiver hold-off so the input backs up, then a full pause
    task automatic test_backpressure();
        set_config(1'b0, 10'd512, 10'd12, 12'd30, 12'd20, 7'd2);
        hold_cycles = 20 * TICK_LATENCY;
        repeat (60) send_item($urandom_range(0, 1), $urandom);
        item_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (150) send_item($urandom_range(0, 2) == 0, $urandom);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SENSOR_MODE;
        cfg_data = '0;
        item_valid = 1'b0;
        cmd = CMD_SAMPLE;
        sample_value = '0;
        predict_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_analog_random();
        test_pulse_random();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("** pulse_rate_speed_estimator: PASSED **");
        else
            $display("** pulse_rate_speed_estimator: FAILED **");
        $finish;
    end
endmodule
